FILE: src/sorted_time_value_table_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted time/value table
// Concurrent checks clocked on aclk and held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_TIME_VALUE_TABLE_UNIT_DEFINES_SVH
`define SORTED_TIME_VALUE_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define STV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define STV_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) cond |=> prop) else $error(msg);
`else
`define STV_ASSERT(lbl, prop, msg)
`define STV_ASSERT_NEXT(lbl, cond, prop, msg)
`endif

`endif

FILE: src/stv_pkg.sv
// ----------------------------------------------------------------------------
// stv_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package stv_pkg;

    localparam int DEPTH    = 256;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = IDX_W + 1;
    localparam int TIME_W   = 32;
    localparam int VAL_W    = 32;
    localparam int VOUT_W   = VAL_W - 1;
    localparam int ABS_W    = 32;
    localparam int REL_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int PROD_W   = VOUT_W + TIME_W;
    localparam int STEP_W   = $clog2(PROD_W);

    localparam logic [CFG_IDX_W-1:0] CFG_ABS_TOL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REL_TOL = 1'd1;

    localparam logic [2:0] OP_SET   = 3'd0;
    localparam logic [2:0] OP_GET   = 3'd1;
    localparam logic [2:0] OP_RMPT  = 3'd2;
    localparam logic [2:0] OP_RMRNG = 3'd3;
    localparam logic [2:0] OP_ADD   = 3'd4;
    localparam logic [2:0] OP_MOVE  = 3'd5;
    localparam logic [2:0] OP_CMPR  = 3'd6;
    localparam logic [2:0] OP_CLEAR = 3'd7;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // memory read address select
    localparam logic [3:0] R_NONE  = 4'd0;
    localparam logic [3:0] R_IDX   = 4'd1;
    localparam logic [3:0] R_IDXM1 = 4'd2;
    localparam logic [3:0] R_IDXP1 = 4'd3;
    localparam logic [3:0] R_END   = 4'd4;
    localparam logic [3:0] R_SRC   = 4'd5;
    localparam logic [3:0] R_PTRM1 = 4'd6;
    localparam logic [3:0] R_CNTM1 = 4'd7;
    localparam logic [3:0] R_IM1   = 4'd8;
    localparam logic [3:0] R_I     = 4'd9;
    localparam logic [3:0] R_IP1   = 4'd10;

    // datapath actions
    localparam logic [4:0] A_NOP       = 5'd0;
    localparam logic [4:0] A_LOAD      = 5'd1;
    localparam logic [4:0] A_IDX_INC   = 5'd2;
    localparam logic [4:0] A_SRCH_DONE = 5'd3;
    localparam logic [4:0] A_SET_VAL   = 5'd4;
    localparam logic [4:0] A_INS_INIT  = 5'd5;
    localparam logic [4:0] A_SHIFT_UP  = 5'd6;
    localparam logic [4:0] A_INS_WR    = 5'd7;
    localparam logic [4:0] A_ERASE_PT  = 5'd8;
    localparam logic [4:0] A_END_INIT  = 5'd9;
    localparam logic [4:0] A_END_INC   = 5'd10;
    localparam logic [4:0] A_ERASE_RNG = 5'd11;
    localparam logic [4:0] A_COPY_DN   = 5'd12;
    localparam logic [4:0] A_ERASE_FIN = 5'd13;
    localparam logic [4:0] A_MOVE_WR   = 5'd14;
    localparam logic [4:0] A_IGNORE    = 5'd15;
    localparam logic [4:0] A_FULL      = 5'd16;
    localparam logic [4:0] A_CLEAR     = 5'd17;
    localparam logic [4:0] A_OUT_CUR   = 5'd18;
    localparam logic [4:0] A_OUT_RD    = 5'd19;
    localparam logic [4:0] A_OUT_IV    = 5'd20;
    localparam logic [4:0] A_GET_SETUP = 5'd21;
    localparam logic [4:0] A_LD_P0     = 5'd22;
    localparam logic [4:0] A_LD_PX     = 5'd23;
    localparam logic [4:0] A_LD_P1     = 5'd24;
    localparam logic [4:0] A_DIV_START = 5'd25;
    localparam logic [4:0] A_IV_LATCH  = 5'd26;
    localparam logic [4:0] A_END_FIX   = 5'd27;
    localparam logic [4:0] A_I_INIT    = 5'd28;
    localparam logic [4:0] A_I_INC     = 5'd29;
    localparam logic [4:0] A_ERASE_I   = 5'd30;
    localparam logic [4:0] A_OUT_LOAD  = 5'd31;

    typedef struct packed {
        logic [3:0] rd;
        logic [4:0] act;
    } stv_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       idx_lt_cnt;
        logic       idxp1_lt_cnt;
        logic       idx_zero;
        logic       cnt_zero;
        logic       cnt_full;
        logic       found;
        logic       rd_lt_a;
        logic       rd_lt_b;
        logic       rd_le_b;
        logic       ta_gt_tb;
        logic       shift_done;
        logic       src_lt_cnt;
        logic       end_lt_cnt;
        logic       e_ge_s3;
        logic       i_lt_em1;
        logic       within_tol;
        logic       div_busy;
        logic       out_busy;
    } stv_stat_t;

endpackage

FILE: src/stv_muldiv.sv
// ----------------------------------------------------------------------------
// stv_muldiv
// floor(a*b/c): one registered multiply, then restoring division, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module stv_muldiv (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [stv_pkg::VOUT_W-1:0]  a,
    input  logic [stv_pkg::TIME_W-1:0]  b,
    input  logic [stv_pkg::TIME_W-1:0]  c,
    output logic                        busy,
    output logic [stv_pkg::VOUT_W-1:0]  q
);

    logic [stv_pkg::PROD_W-1:0] prod;
    logic [stv_pkg::PROD_W-1:0] dvd_reg;
    logic [stv_pkg::TIME_W-1:0] rem_reg;
    logic [stv_pkg::TIME_W-1:0] den_reg;
    logic [stv_pkg::STEP_W-1:0] step_reg;
    logic                       busy_reg;
    logic [stv_pkg::TIME_W:0]   shifted;
    logic                       ge;

    assign prod    = a * b;
    assign shifted = {rem_reg, dvd_reg[stv_pkg::PROD_W-1]};
    assign ge      = shifted >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end else if (busy_reg) begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == stv_pkg::STEP_W'(stv_pkg::PROD_W - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= prod;
            rem_reg <= '0;
            den_reg <= c;
        end else if (busy_reg) begin
            // shift the next dividend bit in, subtract where it fits
            rem_reg <= ge ? stv_pkg::TIME_W'(shifted - {1'b0, den_reg})
                          : shifted[stv_pkg::TIME_W-1:0];
            dvd_reg <= {dvd_reg[stv_pkg::PROD_W-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign q    = dvd_reg[stv_pkg::VOUT_W-1:0];

endmodule

FILE: src/stv_ctrl.sv
// ----------------------------------------------------------------------------
// stv_ctrl
// Sequencer: search, shift, erase, interpolate and compress loops.
// ----------------------------------------------------------------------------
module stv_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  stv_pkg::stv_stat_t stat,
    output stv_pkg::stv_cmd_t  cmd
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_SRCH   = 5'd1;
    localparam logic [4:0] S_SCMP   = 5'd2;
    localparam logic [4:0] S_DISP   = 5'd3;
    localparam logic [4:0] S_SHRD   = 5'd4;
    localparam logic [4:0] S_SHWR   = 5'd5;
    localparam logic [4:0] S_INSWR  = 5'd6;
    localparam logic [4:0] S_GLAST  = 5'd7;
    localparam logic [4:0] S_GP0    = 5'd8;
    localparam logic [4:0] S_DIVGO  = 5'd9;
    localparam logic [4:0] S_DIVW   = 5'd10;
    localparam logic [4:0] S_IV     = 5'd11;
    localparam logic [4:0] S_ERD    = 5'd12;
    localparam logic [4:0] S_EWR    = 5'd13;
    localparam logic [4:0] S_RRD    = 5'd14;
    localparam logic [4:0] S_RCMP   = 5'd15;
    localparam logic [4:0] S_MV0    = 5'd16;
    localparam logic [4:0] S_MV1    = 5'd17;
    localparam logic [4:0] S_MV2    = 5'd18;
    localparam logic [4:0] S_ESRCH  = 5'd19;
    localparam logic [4:0] S_ECMP   = 5'd20;
    localparam logic [4:0] S_CCHK   = 5'd21;
    localparam logic [4:0] S_CLOOP  = 5'd22;
    localparam logic [4:0] S_C0     = 5'd23;
    localparam logic [4:0] S_C1     = 5'd24;
    localparam logic [4:0] S_C2     = 5'd25;
    localparam logic [4:0] S_FIN    = 5'd26;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd.rd     = stv_pkg::R_NONE;
        cmd.act    = stv_pkg::A_NOP;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.act    = stv_pkg::A_LOAD;
                    state_next = S_SRCH;
                end
            end
            S_SRCH: begin
                if (stat.idx_lt_cnt) begin
                    cmd.rd     = stv_pkg::R_IDX;
                    state_next = S_SCMP;
                end else begin
                    cmd.act    = stv_pkg::A_SRCH_DONE;
                    state_next = S_DISP;
                end
            end
            S_SCMP: begin
                if (stat.rd_lt_a) begin
                    cmd.act    = stv_pkg::A_IDX_INC;
                    state_next = S_SRCH;
                end else begin
                    cmd.act    = stv_pkg::A_SRCH_DONE;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                state_next = S_FIN;
                case (stat.op)
                    stv_pkg::OP_SET: begin
                        if (stat.found) begin
                            cmd.act = stv_pkg::A_SET_VAL;
                        end else if (stat.cnt_full) begin
                            cmd.act = stv_pkg::A_FULL;
                        end else begin
                            cmd.act    = stv_pkg::A_INS_INIT;
                            state_next = S_SHRD;
                        end
                    end
                    stv_pkg::OP_GET: begin
                        if (stat.cnt_zero) begin
                            cmd.act = stv_pkg::A_NOP;
                        end else if (stat.found || stat.idx_zero) begin
                            cmd.act = stv_pkg::A_OUT_CUR;
                        end else if (!stat.idx_lt_cnt) begin
                            cmd.rd     = stv_pkg::R_CNTM1;
                            state_next = S_GLAST;
                        end else begin
                            cmd.rd     = stv_pkg::R_IDXM1;
                            state_next = S_GP0;
                        end
                    end
                    stv_pkg::OP_RMPT: begin
                        if (stat.found) begin
                            cmd.act    = stv_pkg::A_ERASE_PT;
                            state_next = S_ERD;
                        end else begin
                            cmd.act = stv_pkg::A_IGNORE;
                        end
                    end
                    stv_pkg::OP_RMRNG: begin
                        if (stat.ta_gt_tb) begin
                            cmd.act = stv_pkg::A_IGNORE;
                        end else begin
                            cmd.act    = stv_pkg::A_END_INIT;
                            state_next = S_RRD;
                        end
                    end
                    stv_pkg::OP_ADD: begin
                        if (stat.cnt_zero || stat.found) begin
                            cmd.act = stv_pkg::A_IGNORE;
                        end else if (stat.cnt_full) begin
                            cmd.act = stv_pkg::A_FULL;
                        end else begin
                            cmd.act    = stv_pkg::A_INS_INIT;
                            state_next = S_SHRD;
                        end
                    end
                    stv_pkg::OP_MOVE: begin
                        if (!stat.found) begin
                            cmd.act = stv_pkg::A_IGNORE;
                        end else if (!stat.idx_zero) begin
                            cmd.rd     = stv_pkg::R_IDXM1;
                            state_next = S_MV0;
                        end else begin
                            state_next = S_MV1;
                        end
                    end
                    stv_pkg::OP_CMPR: begin
                        if (stat.ta_gt_tb) begin
                            cmd.act = stv_pkg::A_IGNORE;
                        end else if (!stat.cnt_zero) begin
                            cmd.act    = stv_pkg::A_END_INIT;
                            state_next = S_ESRCH;
                        end
                    end
                    default: begin
                        cmd.act = stv_pkg::A_CLEAR;
                    end
                endcase
            end
            S_SHRD: begin
                if (stat.shift_done) begin
                    if (!stat.idx_zero) begin
                        cmd.rd = stv_pkg::R_IDXM1;
                    end
                    state_next = S_INSWR;
                end else begin
                    cmd.rd     = stv_pkg::R_PTRM1;
                    state_next = S_SHWR;
                end
            end
            S_SHWR: begin
                cmd.act    = stv_pkg::A_SHIFT_UP;
                state_next = S_SHRD;
            end
            S_INSWR: begin
                cmd.act    = stv_pkg::A_INS_WR;
                state_next = S_FIN;
            end
            S_GLAST: begin
                cmd.act    = stv_pkg::A_OUT_RD;
                state_next = S_FIN;
            end
            S_GP0: begin
                cmd.act    = stv_pkg::A_GET_SETUP;
                state_next = S_DIVGO;
            end
            S_DIVGO: begin
                cmd.act    = stv_pkg::A_DIV_START;
                state_next = S_DIVW;
            end
            S_DIVW: begin
                if (!stat.div_busy) begin
                    cmd.act    = stv_pkg::A_IV_LATCH;
                    state_next = S_IV;
                end
            end
            S_IV: begin
                if (stat.op == stv_pkg::OP_GET) begin
                    cmd.act    = stv_pkg::A_OUT_IV;
                    state_next = S_FIN;
                end else if (stat.within_tol) begin
                    cmd.act    = stv_pkg::A_ERASE_I;
                    state_next = S_ERD;
                end else begin
                    cmd.act    = stv_pkg::A_I_INC;
                    state_next = S_CLOOP;
                end
            end
            S_ERD: begin
                if (stat.src_lt_cnt) begin
                    cmd.rd     = stv_pkg::R_SRC;
                    state_next = S_EWR;
                end else begin
                    cmd.act    = stv_pkg::A_ERASE_FIN;
                    state_next = (stat.op == stv_pkg::OP_CMPR) ? S_CLOOP : S_FIN;
                end
            end
            S_EWR: begin
                cmd.act    = stv_pkg::A_COPY_DN;
                state_next = S_ERD;
            end
            S_RRD: begin
                if (stat.end_lt_cnt) begin
                    cmd.rd     = stv_pkg::R_END;
                    state_next = S_RCMP;
                end else begin
                    cmd.act    = stv_pkg::A_ERASE_RNG;
                    state_next = S_ERD;
                end
            end
            S_RCMP: begin
                if (stat.rd_le_b) begin
                    cmd.act    = stv_pkg::A_END_INC;
                    state_next = S_RRD;
                end else begin
                    cmd.act    = stv_pkg::A_ERASE_RNG;
                    state_next = S_ERD;
                end
            end
            S_MV0: begin
                if (!stat.rd_lt_b) begin
                    cmd.act    = stv_pkg::A_IGNORE;
                    state_next = S_FIN;
                end else begin
                    state_next = S_MV1;
                end
            end
            S_MV1: begin
                if (stat.idxp1_lt_cnt) begin
                    cmd.rd     = stv_pkg::R_IDXP1;
                    state_next = S_MV2;
                end else begin
                    cmd.act    = stv_pkg::A_MOVE_WR;
                    state_next = S_FIN;
                end
            end
            S_MV2: begin
                cmd.act    = stat.rd_le_b ? stv_pkg::A_IGNORE : stv_pkg::A_MOVE_WR;
                state_next = S_FIN;
            end
            S_ESRCH: begin
                if (stat.end_lt_cnt) begin
                    cmd.rd     = stv_pkg::R_END;
                    state_next = S_ECMP;
                end else begin
                    cmd.act    = stv_pkg::A_END_FIX;
                    state_next = S_CCHK;
                end
            end
            S_ECMP: begin
                if (stat.rd_lt_b) begin
                    cmd.act    = stv_pkg::A_END_INC;
                    state_next = S_ESRCH;
                end else begin
                    cmd.act    = stv_pkg::A_END_FIX;
                    state_next = S_CCHK;
                end
            end
            S_CCHK: begin
                if (stat.e_ge_s3) begin
                    cmd.act    = stv_pkg::A_I_INIT;
                    state_next = S_CLOOP;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_CLOOP: begin
                if (stat.i_lt_em1) begin
                    cmd.rd     = stv_pkg::R_IM1;
                    state_next = S_C0;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_C0: begin
                cmd.act    = stv_pkg::A_LD_P0;
                cmd.rd     = stv_pkg::R_I;
                state_next = S_C1;
            end
            S_C1: begin
                cmd.act    = stv_pkg::A_LD_PX;
                cmd.rd     = stv_pkg::R_IP1;
                state_next = S_C2;
            end
            S_C2: begin
                cmd.act    = stv_pkg::A_LD_P1;
                state_next = S_DIVGO;
            end
            S_FIN: begin
                if (!stat.out_busy) begin
                    cmd.act    = stv_pkg::A_OUT_LOAD;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == S_IDLE);

endmodule

FILE: src/stv_dpath.sv
// ----------------------------------------------------------------------------
// stv_dpath
// Point memories, index registers, interpolation and result registers.
// ----------------------------------------------------------------------------
module stv_dpath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  stv_pkg::stv_cmd_t              cmd,
    output stv_pkg::stv_stat_t             stat,
    input  logic [2:0]                     s_operation,
    input  logic [stv_pkg::TIME_W-1:0]     s_time_a,
    input  logic [stv_pkg::TIME_W-1:0]     s_time_b,
    input  logic signed [stv_pkg::VAL_W-1:0] s_value_in,
    input  logic                           cfg_wr_en,
    input  logic [stv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [stv_pkg::ABS_W-1:0]      cfg_wdata,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [stv_pkg::VOUT_W-1:0]     m_value_out,
    output logic                           m_exact_hit,
    output logic [1:0]                     m_status,
    output logic [stv_pkg::CNT_W-1:0]      m_point_count
);

    localparam int TW = stv_pkg::TIME_W;
    localparam int VW = stv_pkg::VAL_W;
    localparam int CW = stv_pkg::CNT_W;
    localparam int IW = stv_pkg::IDX_W;

    logic [TW-1:0] tmem [stv_pkg::DEPTH];
    logic [VW-1:0] vmem [stv_pkg::DEPTH];

    logic [2:0]    op_reg;
    logic [TW-1:0] ta_reg, tb_reg;
    logic [VW-1:0] vin_reg;
    logic [CW-1:0] cnt_reg, idx_reg, end_reg, ptr_reg, src_reg, i_reg;
    logic [TW-1:0] rd_t_reg, cur_t_reg, t0_reg, t1_reg, tx_reg;
    logic [VW-1:0] rd_v_reg, cur_v_reg, v0_reg, v1_reg, vx_reg, iv_reg;
    logic          found_reg, hit_reg, dir_reg;
    logic [1:0]    status_reg;
    logic [stv_pkg::VOUT_W-1:0] vout_reg;
    logic [stv_pkg::ABS_W-1:0]  abs_tol_reg;
    logic [stv_pkg::REL_W-1:0]  rel_tol_reg;
    logic [stv_pkg::ABS_W:0]    tol_reg;
    logic          m_valid_reg;

    logic [CW-1:0] raddr;
    logic          t_we, v_we;
    logic [CW-1:0] waddr;
    logic [TW-1:0] wdata_t;
    logic [VW-1:0] wdata_v;
    logic          div_busy;
    logic [stv_pkg::VOUT_W-1:0] div_q;
    logic [stv_pkg::VOUT_W-1:0] vdiff;
    logic [VW-1:0] iv_next, tol_diff;
    logic [stv_pkg::VOUT_W+stv_pkg::REL_W-1:0] rel_prod;
    logic          srch_found;

    // read address select
    always_comb begin
        case (cmd.rd)
            stv_pkg::R_IDX:   raddr = idx_reg;
            stv_pkg::R_IDXM1: raddr = idx_reg - 1'b1;
            stv_pkg::R_IDXP1: raddr = idx_reg + 1'b1;
            stv_pkg::R_END:   raddr = end_reg;
            stv_pkg::R_SRC:   raddr = src_reg;
            stv_pkg::R_PTRM1: raddr = ptr_reg - 1'b1;
            stv_pkg::R_CNTM1: raddr = cnt_reg - 1'b1;
            stv_pkg::R_IM1:   raddr = i_reg - 1'b1;
            stv_pkg::R_I:     raddr = i_reg;
            stv_pkg::R_IP1:   raddr = i_reg + 1'b1;
            default:          raddr = '0;
        endcase
    end

    // write port
    always_comb begin
        t_we    = 1'b0;
        v_we    = 1'b0;
        waddr   = ptr_reg;
        wdata_t = rd_t_reg;
        wdata_v = rd_v_reg;
        case (cmd.act)
            stv_pkg::A_SET_VAL: begin
                v_we    = 1'b1;
                waddr   = idx_reg;
                wdata_v = vin_reg;
            end
            stv_pkg::A_SHIFT_UP, stv_pkg::A_COPY_DN: begin
                t_we = 1'b1;
                v_we = 1'b1;
            end
            stv_pkg::A_INS_WR: begin
                t_we    = 1'b1;
                v_we    = 1'b1;
                waddr   = idx_reg;
                wdata_t = ta_reg;
                if (op_reg == stv_pkg::OP_SET) begin
                    wdata_v = vin_reg;
                end else if (idx_reg == '0) begin
                    wdata_v = '0;
                end
            end
            stv_pkg::A_MOVE_WR: begin
                t_we    = 1'b1;
                waddr   = idx_reg;
                wdata_t = tb_reg;
            end
            default: begin
                t_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (t_we) begin
            tmem[waddr[IW-1:0]] <= wdata_t;
        end
        if (v_we) begin
            vmem[waddr[IW-1:0]] <= wdata_v;
        end
        if (cmd.rd != stv_pkg::R_NONE) begin
            rd_t_reg <= tmem[raddr[IW-1:0]];
            rd_v_reg <= vmem[raddr[IW-1:0]];
        end
    end

    assign srch_found = (idx_reg < cnt_reg) && (rd_t_reg == ta_reg);
    assign vdiff      = (v1_reg >= v0_reg) ? stv_pkg::VOUT_W'(v1_reg - v0_reg)
                                           : stv_pkg::VOUT_W'(v0_reg - v1_reg);
    assign rel_prod   = vx_reg[stv_pkg::VOUT_W-1:0] * rel_tol_reg;
    assign iv_next    = dir_reg ? v0_reg + VW'(div_q) : v0_reg - VW'(div_q);
    assign tol_diff   = (vx_reg >= iv_reg) ? vx_reg - iv_reg : iv_reg - vx_reg;

    stv_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.act == stv_pkg::A_DIV_START),
        .a       (vdiff),
        .b       (tx_reg - t0_reg),
        .c       (t1_reg - t0_reg),
        .busy    (div_busy),
        .q       (div_q)
    );

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            abs_tol_reg <= '0;
            rel_tol_reg <= '0;
        end else begin
            if (cfg_wr_en && cfg_index == stv_pkg::CFG_ABS_TOL) begin
                abs_tol_reg <= cfg_wdata;
            end
            if (cfg_wr_en && cfg_index == stv_pkg::CFG_REL_TOL) begin
                rel_tol_reg <= cfg_wdata[stv_pkg::REL_W-1:0];
            end
            if (cmd.act == stv_pkg::A_OUT_LOAD) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (cmd.act)
                stv_pkg::A_INS_WR:    cnt_reg <= cnt_reg + 1'b1;
                stv_pkg::A_ERASE_FIN: cnt_reg <= ptr_reg;
                stv_pkg::A_CLEAR:     cnt_reg <= '0;
                default:              cnt_reg <= cnt_reg;
            endcase
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        case (cmd.act)
            stv_pkg::A_LOAD: begin
                op_reg     <= s_operation;
                ta_reg     <= s_time_a;
                tb_reg     <= s_time_b;
                vin_reg    <= s_value_in[VW-1] ? '0 : VW'(s_value_in);
                idx_reg    <= '0;
                hit_reg    <= 1'b0;
                status_reg <= stv_pkg::ST_DONE;
                vout_reg   <= '0;
            end
            stv_pkg::A_IDX_INC: idx_reg <= idx_reg + 1'b1;
            stv_pkg::A_SRCH_DONE: begin
                found_reg <= srch_found;
                hit_reg   <= srch_found && (op_reg inside {stv_pkg::OP_SET, stv_pkg::OP_GET,
                             stv_pkg::OP_RMPT, stv_pkg::OP_ADD, stv_pkg::OP_MOVE});
                cur_t_reg <= rd_t_reg;
                cur_v_reg <= rd_v_reg;
            end
            stv_pkg::A_INS_INIT: ptr_reg <= cnt_reg;
            stv_pkg::A_SHIFT_UP: ptr_reg <= ptr_reg - 1'b1;
            stv_pkg::A_ERASE_PT: begin
                ptr_reg <= idx_reg;
                src_reg <= idx_reg + 1'b1;
            end
            stv_pkg::A_END_INIT: end_reg <= idx_reg;
            stv_pkg::A_END_INC:  end_reg <= end_reg + 1'b1;
            stv_pkg::A_END_FIX: begin
                if (end_reg == cnt_reg) begin
                    end_reg <= end_reg - 1'b1;
                end
            end
            stv_pkg::A_ERASE_RNG: begin
                ptr_reg <= idx_reg;
                src_reg <= end_reg;
            end
            stv_pkg::A_COPY_DN: begin
                ptr_reg <= ptr_reg + 1'b1;
                src_reg <= src_reg + 1'b1;
            end
            stv_pkg::A_IGNORE: status_reg <= stv_pkg::ST_IGNORED;
            stv_pkg::A_FULL:   status_reg <= stv_pkg::ST_FULL;
            stv_pkg::A_OUT_CUR: vout_reg <= cur_v_reg[stv_pkg::VOUT_W-1:0];
            stv_pkg::A_OUT_RD:  vout_reg <= rd_v_reg[stv_pkg::VOUT_W-1:0];
            stv_pkg::A_OUT_IV:  vout_reg <= iv_reg[stv_pkg::VOUT_W-1:0];
            stv_pkg::A_GET_SETUP: begin
                t0_reg <= rd_t_reg;
                v0_reg <= rd_v_reg;
                t1_reg <= cur_t_reg;
                v1_reg <= cur_v_reg;
                tx_reg <= ta_reg;
            end
            stv_pkg::A_LD_P0: begin
                t0_reg <= rd_t_reg;
                v0_reg <= rd_v_reg;
            end
            stv_pkg::A_LD_PX: begin
                tx_reg <= rd_t_reg;
                vx_reg <= rd_v_reg;
            end
            stv_pkg::A_LD_P1: begin
                t1_reg <= rd_t_reg;
                v1_reg <= rd_v_reg;
            end
            stv_pkg::A_DIV_START: begin
                dir_reg <= v1_reg >= v0_reg;
                tol_reg <= (stv_pkg::ABS_W+1)'(rel_prod[stv_pkg::VOUT_W+stv_pkg::REL_W-1:
                           stv_pkg::REL_W]) + (stv_pkg::ABS_W+1)'(abs_tol_reg);
            end
            stv_pkg::A_IV_LATCH: iv_reg <= iv_next;
            stv_pkg::A_I_INIT:   i_reg <= idx_reg + 1'b1;
            stv_pkg::A_I_INC:    i_reg <= i_reg + 1'b1;
            stv_pkg::A_ERASE_I: begin
                ptr_reg <= i_reg;
                src_reg <= i_reg + 1'b1;
                end_reg <= end_reg - 1'b1;
            end
            stv_pkg::A_OUT_LOAD: begin
                m_value_out   <= vout_reg;
                m_exact_hit   <= hit_reg;
                m_status      <= status_reg;
                m_point_count <= cnt_reg;
            end
            default: begin
                op_reg <= op_reg;
            end
        endcase
    end

    always_comb begin
        stat.op           = op_reg;
        stat.idx_lt_cnt   = idx_reg < cnt_reg;
        stat.idxp1_lt_cnt = {1'b0, idx_reg} + 1'b1 < {1'b0, cnt_reg};
        stat.idx_zero     = idx_reg == '0;
        stat.cnt_zero     = cnt_reg == '0;
        stat.cnt_full     = cnt_reg == CW'(stv_pkg::DEPTH);
        stat.found        = found_reg;
        stat.rd_lt_a      = rd_t_reg < ta_reg;
        stat.rd_lt_b      = rd_t_reg < tb_reg;
        stat.rd_le_b      = rd_t_reg <= tb_reg;
        stat.ta_gt_tb     = ta_reg > tb_reg;
        stat.shift_done   = ptr_reg == idx_reg;
        stat.src_lt_cnt   = src_reg < cnt_reg;
        stat.end_lt_cnt   = end_reg < cnt_reg;
        stat.e_ge_s3      = {1'b0, end_reg} >= {1'b0, idx_reg} + (CW+1)'(3);
        stat.i_lt_em1     = {1'b0, i_reg} + 1'b1 < {1'b0, end_reg};
        stat.within_tol   = {1'b0, tol_diff} <= tol_reg;
        stat.div_busy     = div_busy;
        stat.out_busy     = m_valid_reg && !m_ready;
    end

    assign m_valid = m_valid_reg;

endmodule

FILE: src/sorted_time_value_table_unit.sv
// ----------------------------------------------------------------------------
// sorted_time_value_table_unit
// Time-sorted table of up to 256 (time, value) points with set, get with
// linear interpolation, point and range removal, add, move and compress.
// ----------------------------------------------------------------------------
// Each accepted word runs one operation and returns one result word. Points
// live in a single-port-write, one-read memory; a sequencer walks it one
// entry at a time. Every operation, clear included, first runs the
// lower-bound search on time_a, then shifts entries one by one on an insert
// or removal. A get between two points adds the interpolation (neighbor
// load, divider start, 63 serial divide steps and the quotient latch). A
// compress pass runs the interpolation on each inner point it checks, plus
// the erase shift for each point it drops. A new word is taken once the
// previous one has been moved into the output register, so the next word
// may start while a result still waits for m_ready. Write the tolerance
// registers (0 absolute, 1 relative) only while the unit is idle.
// ----------------------------------------------------------------------------
`include "sorted_time_value_table_unit_defines.svh"

module sorted_time_value_table_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input words
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [2:0]                       s_operation,
    input  logic [stv_pkg::TIME_W-1:0]       s_time_a,
    input  logic [stv_pkg::TIME_W-1:0]       s_time_b,
    input  logic signed [stv_pkg::VAL_W-1:0] s_value_in,
    // result words
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [stv_pkg::VOUT_W-1:0]       m_value_out,
    output logic                             m_exact_hit,
    output logic [1:0]                       m_status,
    output logic [stv_pkg::CNT_W-1:0]        m_point_count,
    // tolerance register writes
    input  logic                             cfg_wr_en,
    input  logic [stv_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [stv_pkg::ABS_W-1:0]        cfg_wdata
);

    stv_pkg::stv_cmd_t  cmd;
    stv_pkg::stv_stat_t stat;
    logic               full_word;
    logic               table_full;
    logic               ignored_word;

    // sequencer: decide each cycle's memory read and datapath action
    stv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // storage, arithmetic and the output register
    stv_dpath u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_operation   (s_operation),
        .s_time_a      (s_time_a),
        .s_time_b      (s_time_b),
        .s_value_in    (s_value_in),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_value_out   (m_value_out),
        .m_exact_hit   (m_exact_hit),
        .m_status      (m_status),
        .m_point_count (m_point_count)
    );

    assign full_word    = m_valid && (m_status == stv_pkg::ST_FULL);
    assign table_full   = m_point_count == stv_pkg::CNT_W'(stv_pkg::DEPTH);
    assign ignored_word = m_valid && (m_status == stv_pkg::ST_IGNORED);

    // one word in flight: drop ready right after an accept
    `STV_ASSERT_NEXT(a_one_in_flight, (s_valid && s_ready), !s_ready, "ready held after accept")
    // a full status only comes with a full table
    `STV_ASSERT(a_full_count, full_word |-> table_full, "full status with room left")
    // only get returns a value, and get is never ignored
    `STV_ASSERT(a_ignored_no_value, ignored_word |-> (m_value_out == '0), "value on ignored word")

endmodule

FILE: tb/sorted_time_value_table_checker.sv
// ----------------------------------------------------------------------------
// Sorted time/value table checker
// Watches the word and tolerance ports, keeps its own copy of the table,
// predicts each result word and compares it field by field.
// ----------------------------------------------------------------------------
module sorted_time_value_table_checker
    import stv_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic [2:0]               s_operation,
    input  logic [TIME_W-1:0]        s_time_a,
    input  logic [TIME_W-1:0]        s_time_b,
    input  logic signed [VAL_W-1:0]  s_value_in,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic [VOUT_W-1:0]        m_value_out,
    input  logic                     m_exact_hit,
    input  logic [1:0]               m_status,
    input  logic [CNT_W-1:0]         m_point_count,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [ABS_W-1:0]         cfg_wdata,
    output int                       fail_count,
    output int                       pending
);

    typedef struct {
        logic [VOUT_W-1:0] value;
        logic              hit;
        logic [1:0]        status;
        logic [CNT_W-1:0]  count;
    } table_result_t;

    logic [TIME_W-1:0] point_time [DEPTH];
    logic [VAL_W-1:0]  point_value [DEPTH];
    int unsigned       n_points;
    logic [ABS_W-1:0]  abs_tol;
    logic [REL_W-1:0]  rel_tol;
    table_result_t     expected_results [$];

    assign pending = expected_results.size();

    function automatic int unsigned lower_bound(input logic [TIME_W-1:0] t);
        int unsigned i;
        i = 0;
        while (i < n_points && point_time[i] < t)
            i++;
        return i;
    endfunction

    // v0 + (v1-v0)*(t-t0)/(t1-t0), offset truncated toward zero
    function automatic logic [VAL_W-1:0] interp_value(input logic [VAL_W-1:0] v0,
            input logic [TIME_W-1:0] t0, input logic [VAL_W-1:0] v1,
            input logic [TIME_W-1:0] t1, input logic [TIME_W-1:0] t);
        longint unsigned span, dt;
        span = longint'(t1) - longint'(t0);
        dt   = longint'(t) - longint'(t0);
        if (span == 0)
            return v0;
        if (v1 >= v0)
            return v0 + VAL_W'((longint'(v1 - v0) * dt) / span);
        return v0 - VAL_W'((longint'(v0 - v1) * dt) / span);
    endfunction

    task automatic erase_points(input int unsigned first, input int unsigned last_excl);
        int unsigned k;
        for (k = first; k + (last_excl - first) < n_points; k++) begin
            point_time[k]  = point_time[k + last_excl - first];
            point_value[k] = point_value[k + last_excl - first];
        end
        n_points -= last_excl - first;
    endtask

    task automatic insert_point(input int unsigned idx, input logic [TIME_W-1:0] t,
                                input logic [VAL_W-1:0] v);
        int unsigned k;
        for (k = n_points; k > idx; k--) begin
            point_time[k]  = point_time[k - 1];
            point_value[k] = point_value[k - 1];
        end
        point_time[idx]  = t;
        point_value[idx] = v;
        n_points++;
    endtask

    task automatic predict_table_word(input logic [2:0] op, input logic [TIME_W-1:0] ta,
            input logic [TIME_W-1:0] tb, input logic signed [VAL_W-1:0] vraw);
        table_result_t     r;
        logic [VAL_W-1:0]  vin;
        int unsigned       idx, last, s, e, i;
        logic              found;
        longint unsigned   v, iv, diff, tol;
        vin   = vraw[VAL_W-1] ? '0 : vraw;
        idx   = lower_bound(ta);
        found = idx < n_points && point_time[idx] == ta;
        r.value  = '0;
        r.status = ST_DONE;
        r.hit    = (op == OP_RMRNG || op == OP_CMPR || op == OP_CLEAR) ? 1'b0 : found;
        case (op)
            OP_SET: begin
                if (found)
                    point_value[idx] = vin;
                else if (n_points >= DEPTH)
                    r.status = ST_FULL;
                else
                    insert_point(idx, ta, vin);
            end
            OP_GET: begin
                if (n_points == 0)
                    r.value = '0;
                else if (found)
                    r.value = VOUT_W'(point_value[idx]);
                else if (idx == 0)
                    r.value = VOUT_W'(point_value[0]);
                else if (idx == n_points)
                    r.value = VOUT_W'(point_value[n_points - 1]);
                else
                    r.value = VOUT_W'(interp_value(point_value[idx - 1],
                                                   point_time[idx - 1],
                                                   point_value[idx], point_time[idx], ta));
            end
            OP_RMPT: begin
                if (found)
                    erase_points(idx, idx + 1);
                else
                    r.status = ST_IGNORED;
            end
            OP_RMRNG: begin
                if (ta > tb) begin
                    r.status = ST_IGNORED;
                end else begin
                    last = idx;
                    while (last < n_points && point_time[last] <= tb)
                        last++;
                    erase_points(idx, last);
                end
            end
            OP_ADD: begin
                if (n_points == 0 || found)
                    r.status = ST_IGNORED;
                else if (n_points >= DEPTH)
                    r.status = ST_FULL;
                else
                    insert_point(idx, ta, idx != 0 ? point_value[idx - 1] : '0);
            end
            OP_MOVE: begin
                if (!found)
                    r.status = ST_IGNORED;
                else if ((idx > 0 && point_time[idx - 1] >= tb) ||
                         (idx + 1 < n_points && point_time[idx + 1] <= tb))
                    r.status = ST_IGNORED;
                else
                    point_time[idx] = tb;
            end
            OP_CMPR: begin
                if (ta > tb) begin
                    r.status = ST_IGNORED;
                end else if (n_points > 0) begin
                    s = idx;
                    e = lower_bound(tb);
                    if (e == n_points)
                        e--;
                    if (e >= s + 3) begin
                        i = s + 1;
                        while (i < e - 1) begin
                            v    = 64'(point_value[i]);
                            iv   = 64'(interp_value(point_value[i - 1], point_time[i - 1],
                                                    point_value[i + 1], point_time[i + 1],
                                                    point_time[i]));
                            diff = v >= iv ? v - iv : iv - v;
                            tol  = ((v * rel_tol) >> 16) + abs_tol;
                            if (diff <= tol) begin
                                erase_points(i, i + 1);
                                e--;
                            end else begin
                                i++;
                            end
                        end
                    end
                end
            end
            default: n_points = 0;
        endcase
        r.count = CNT_W'(n_points);
        expected_results.insert(expected_results.size(), r);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            n_points   = 0;
            abs_tol    = '0;
            rel_tol    = '0;
            fail_count = 0;
            expected_results.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == CFG_ABS_TOL)
                    abs_tol = cfg_wdata;
                else
                    rel_tol = cfg_wdata[REL_W-1:0];
            end
            // Compare before predicting so a same-edge word cannot be matched early.
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result word value=%h hit=%b status=%0d count=%0d",
                             $time, m_value_out, m_exact_hit, m_status, m_point_count);
                    fail_count++;
                end else begin
                    table_result_t r;
                    r = expected_results.pop_front();
                    if (m_value_out !== r.value) begin
                        $display("%0t: value_out expected %h actual %h",
                                 $time, r.value, m_value_out);
                        fail_count++;
                    end
                    if (m_exact_hit !== r.hit) begin
                        $display("%0t: exact_hit expected %b actual %b",
                                 $time, r.hit, m_exact_hit);
                        fail_count++;
                    end
                    if (m_status !== r.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, r.status, m_status);
                        fail_count++;
                    end
                    if (m_point_count !== r.count) begin
                        $display("%0t: point_count expected %0d actual %0d",
                                 $time, r.count, m_point_count);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                predict_table_word(s_operation, s_time_a, s_time_b, s_value_in);
        end
    end

endmodule

FILE: tb/tb_sorted_time_value_table_unit.sv
// ----------------------------------------------------------------------------
// Sorted time/value table testbench
// Drives operation words and tolerance writes into the table unit, with
// random gaps on both channels, and lets the checker judge every result.
// ----------------------------------------------------------------------------
module tb_sorted_time_value_table_unit;
    import stv_pkg::*;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic [2:0]              s_operation;
    logic [TIME_W-1:0]       s_time_a;
    logic [TIME_W-1:0]       s_time_b;
    logic signed [VAL_W-1:0] s_value_in;
    logic                    m_valid;
    logic                    m_ready;
    logic [VOUT_W-1:0]       m_value_out;
    logic                    m_exact_hit;
    logic [1:0]              m_status;
    logic [CNT_W-1:0]        m_point_count;
    logic                    cfg_wr_en;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [ABS_W-1:0]        cfg_wdata;
    int                      fail_count;
    int                      pending;

    // quiet: no idling on either side; hold_req: ask the receiver for one long stall
    logic                    quiet;
    logic                    hold_req;

    sorted_time_value_table_unit dut (.*);

    sorted_time_value_table_checker checker_i (.*);

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #(8 * 4_000_000);
        $display("tb_sorted_time_value_table_unit NOT OK");
        $finish;
    end

    // Result side: mostly ready, short and occasional long stalls, one long hold on request.
    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready  = 1'b0;
                repeat (1500) @(negedge aclk);
            end else if (quiet) begin
                m_ready = 1'b1;
            end else if ($urandom_range(0, 99) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(20, 80)) @(negedge aclk);
            end else begin
                m_ready = $urandom_range(0, 9) < 7;
            end
        end
    end

    function automatic int gap_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Mostly a dense grid of small ticks so hits and neighbours happen often.
    function automatic logic [TIME_W-1:0] pick_tick();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(0, 48) * 8 +
                   ($urandom_range(0, 3) == 0 ? $urandom_range(1, 7) : 0);
        if (r < 90)
            return $urandom;
        case ($urandom_range(0, 2))
            0: return '0;
            1: return '1;
            default: return 32'hFFFF_FFFE;
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $urandom_range(0, 32'h0004_0000);
        if (r < 80)
            return $urandom;
        case ($urandom_range(0, 3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            default: return '0;
        endcase
    endfunction

    // Offer one word from a falling edge, hold it until taken, then idle.
    task automatic send_word(input logic [2:0] op, input logic [TIME_W-1:0] ta,
                             input logic [TIME_W-1:0] tb, input logic [VAL_W-1:0] v);
        int gap;
        s_operation = op;
        s_time_a    = ta;
        s_time_b    = tb;
        s_value_in  = v;
        s_valid     = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        s_valid = 1'b0;
        gap = gap_cycles();
        repeat (gap) @(negedge aclk);
    endtask

    task automatic send_random_word();
        logic [TIME_W-1:0] ta, tb;
        logic [2:0]        op;
        int                r;
        r  = $urandom_range(0, 99);
        ta = pick_tick();
        if (r < 30)      op = OP_SET;
        else if (r < 55) op = OP_GET;
        else if (r < 63) op = OP_RMPT;
        else if (r < 70) op = OP_RMRNG;
        else if (r < 80) op = OP_ADD;
        else if (r < 88) op = OP_MOVE;
        else if (r < 97) op = OP_CMPR;
        else             op = OP_CLEAR;
        case (op)
            OP_MOVE:
                tb = $urandom_range(0, 1) ? ta + $urandom_range(0, 12)
                                          : ta - $urandom_range(0, 12);
            OP_RMRNG, OP_CMPR: begin
                // mostly ordered ranges, some reversed
                tb = pick_tick();
                if ($urandom_range(0, 9) < 8 && ta > tb)
                    tb = ta + $urandom_range(0, 96);
                if (op == OP_RMRNG && $urandom_range(0, 1))
                    tb = ta + $urandom_range(0, 16);
            end
            default: tb = $urandom;
        endcase
        send_word(op, ta, tb, pick_value());
    endtask

    task automatic wait_idle();
        while (pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_tolerance(input logic [CFG_IDX_W-1:0] idx, input logic [ABS_W-1:0] d);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = d;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic run_phase(input logic [ABS_W-1:0] abs_t, input logic [REL_W-1:0] rel_t,
                             input int n);
        wait_idle();
        write_tolerance(CFG_ABS_TOL, abs_t);
        write_tolerance(CFG_REL_TOL, ABS_W'(rel_t));
        repeat (n) send_random_word();
    endtask

    initial begin
        int k;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_operation = OP_SET;
        s_time_a    = '0;
        s_time_b    = '0;
        s_value_in  = '0;
        cfg_wr_en   = 1'b0;
        cfg_index   = CFG_ABS_TOL;
        cfg_wdata   = '0;
        quiet       = 1'b0;
        hold_req    = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: empty table, clamping, extremes, every operation and its corner cases.
        send_word(OP_GET,   5, 0, 0);
        send_word(OP_ADD,   5, 0, 0);
        send_word(OP_SET,   100, 0, 32'h0001_0000);
        send_word(OP_SET,   0, 0, 32'hFFFF_FFFF);
        send_word(OP_SET,   32'hFFFF_FFFF, 0, 32'h7FFF_FFFF);
        send_word(OP_SET,   300, 0, 32'h8000_0000);
        send_word(OP_GET,   50, 0, 0);
        send_word(OP_GET,   100, 0, 0);
        send_word(OP_GET,   32'h8000_0000, 0, 0);
        send_word(OP_SET,   100, 0, 32'h0003_0000);
        send_word(OP_ADD,   100, 0, 0);
        send_word(OP_ADD,   150, 0, 0);
        send_word(OP_MOVE,  150, 160, 0);
        send_word(OP_MOVE,  160, 100, 0);
        send_word(OP_MOVE,  160, 160, 0);
        send_word(OP_MOVE,  777, 780, 0);
        send_word(OP_RMPT,  777, 0, 0);
        send_word(OP_RMPT,  160, 0, 0);
        send_word(OP_RMRNG, 300, 200, 0);
        send_word(OP_CMPR,  300, 200, 0);
        send_word(OP_SET,   400, 0, 32'h0004_0000);
        send_word(OP_CMPR,  0, 32'hFFFF_FFFF, 0);
        send_word(OP_RMRNG, 0, 32'hFFFF_FFFE, 0);
        send_word(OP_GET,   0, 0, 0);
        send_word(OP_CLEAR, 0, 0, 0);

        // Random phases across tolerance settings, extremes included.
        run_phase('0, '0, 70);
        run_phase('1, '1, 70);
        run_phase($urandom_range(0, 32'h0002_0000), REL_W'($urandom_range(0, 16'hFFFF)), 70);
        run_phase(32'h0000_4000, 16'h0800, 70);

        // Fill to capacity while the receiver holds off, then hit the full cases.
        wait_idle();
        send_word(OP_CLEAR, 0, 0, 0);
        hold_req = 1'b1;
        for (k = 0; k < DEPTH; k++)
            send_word(OP_SET, k * 1024 + 512, 0, pick_value());
        send_word(OP_SET,  5, 0, pick_value());
        send_word(OP_ADD,  700, 0, 0);
        send_word(OP_SET,  512, 0, pick_value());
        repeat (6) send_word(OP_GET, $urandom_range(0, DEPTH * 1024 + 1024), 0, 0);
        send_word(OP_CMPR, 0, 20000, 0);

        // Back-to-back with no idling on either side.
        wait_idle();
        quiet = 1'b1;
        run_phase(32'h0001_0000, 16'h0100, 80);

        wait_idle();
        repeat (100) @(posedge aclk);
        if (fail_count == 0)
            $display("tb_sorted_time_value_table_unit OK");
        else
            $display("tb_sorted_time_value_table_unit NOT OK");
        $finish;
    end

endmodule

FILE: sorted_time_value_table_unit.f
+incdir+src
src/stv_pkg.sv
src/stv_muldiv.sv
src/stv_ctrl.sv
src/stv_dpath.sv
src/sorted_time_value_table_unit.sv
tb/sorted_time_value_table_checker.sv
tb/tb_sorted_time_value_table_unit.sv
